// ===== rtl/vagdec_pkg.sv =====
// ----------------------------------------------------------------------------
// vagdec_pkg
// Types, constants and predictor coefficients for the VAG ADPCM decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vagdec_pkg;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       channel;
    logic       end_of_call;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               sample_channel;
    logic               last_of_pair;
  } out_t;

  // work handed from the frame parser to the sample datapath
  typedef struct packed {
    logic [7:0] data;
    logic       channel;
    logic       decode;
    logic       clear;
    logic [2:0] pred;
    logic [3:0] shift;
  } job_t;

  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_FLAGS  = 4'd1;
  localparam logic [3:0] FRAME_LAST = 4'd15;
  localparam logic [3:0] MAX_SHIFT  = 4'd12;
  localparam logic [7:0] HALT_FLAG  = 8'h07;
  localparam logic [3:0] NUM_PRED   = 4'd5;

  localparam logic signed [25:0] SAT_MAX = 26'sd32767;
  localparam logic signed [25:0] SAT_MIN = -26'sd32768;

  function automatic logic signed [7:0] coef_a(input logic [2:0] p);
    logic signed [7:0] c;
    case (p)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_b(input logic [2:0] p);
    logic signed [7:0] c;
    case (p)
      3'd2:    c = 8'sd52;
      3'd3:    c = 8'sd55;
      3'd4:    c = 8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vagdec_fifo.sv =====
// ----------------------------------------------------------------------------
// vagdec_fifo
// Small show-ahead register queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module vagdec_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PW'(DEPTH-1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PW'(DEPTH-1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vagdec_front.sv =====
// ----------------------------------------------------------------------------
// vagdec_front
// Frame parser: tracks byte position, header, flags and halt; issues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module vagdec_front
  import vagdec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic accept,
  input  wire in_t  item,
  output logic      job_valid,
  output job_t      job
);

  logic [3:0] pos_r, pos_nxt;
  logic [3:0] pred_r, pred_nxt;
  logic [3:0] shift_r, shift_nxt;
  logic [7:0] flags_r, flags_nxt;
  logic       halted_r, halted_nxt;
  logic       decode;
  logic       clear;
  logic [7:0] b;

  assign b = item.stream_byte;

  always_comb begin
    pos_nxt    = pos_r;
    pred_nxt   = pred_r;
    shift_nxt  = shift_r;
    flags_nxt  = flags_r;
    halted_nxt = halted_r;
    decode     = 1'b0;
    if (!halted_r) begin
      case (pos_r)
        POS_HEADER: begin
          shift_nxt = b[3:0];
          pred_nxt  = b[7:4];
          if (b[3:0] > MAX_SHIFT) begin
            halted_nxt = 1'b1;
          end
        end
        POS_FLAGS: begin
          flags_nxt = b;
          if (b == HALT_FLAG) begin
            halted_nxt = 1'b1;
          end
        end
        default: begin
          decode = (pred_r < NUM_PRED);
        end
      endcase
      if (!halted_nxt) begin
        pos_nxt = (pos_r == FRAME_LAST) ? POS_HEADER : pos_r + 1'b1;
      end
    end
    clear = item.end_of_call && flags_nxt[0];
    if (item.end_of_call) begin
      pos_nxt    = POS_HEADER;
      flags_nxt  = '0;
      halted_nxt = 1'b0;
    end
  end

  assign job_valid   = decode || clear;
  assign job.data    = b;
  assign job.channel = item.channel;
  assign job.decode  = decode;
  assign job.clear   = clear;
  assign job.pred    = pred_r[2:0];
  assign job.shift   = shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      pred_r   <= '0;
      shift_r  <= '0;
      flags_r  <= '0;
      halted_r <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      pred_r   <= pred_nxt;
      shift_r  <= shift_nxt;
      flags_r  <= flags_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vagdec_back.sv =====
// ----------------------------------------------------------------------------
// vagdec_back
// Sample datapath: one nibble per cycle, unless the job queue is empty or the
// result queue is full, through the predictor filter, saturation and per-channel history update.
// ----------------------------------------------------------------------------
`default_nettype none

module vagdec_back
  import vagdec_pkg::*;
#(
  parameter int NUM_CHANNELS = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_empty,
  input  wire job_t job,
  output logic      job_pop,
  input  wire logic res_full,
  output logic      res_push,
  output out_t      res
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic signed [15:0] prev_r  [NUM_CHANNELS];
  logic signed [15:0] prev2_r [NUM_CHANNELS];
  logic               phase_r;

  logic [CH_W-1:0]    idx;
  logic               ch_out;
  logic [3:0]         nib;
  logic signed [15:0] s1, s2, base;
  logic signed [23:0] pa, pb;
  logic signed [24:0] pdiff;
  logic signed [25:0] sum;
  logic signed [15:0] sat;
  logic               step;

  assign idx    = (NUM_CHANNELS > 1) ? CH_W'(job.channel) : '0;
  assign ch_out = (NUM_CHANNELS > 1) ? job.channel : 1'b0;
  assign nib    = phase_r ? job.data[7:4] : job.data[3:0];
  assign s1     = prev_r[idx];
  assign s2     = prev2_r[idx];

  always_comb begin
    base  = $signed({nib, 12'b0}) >>> job.shift;
    pa    = s1 * coef_a(job.pred);
    pb    = s2 * coef_b(job.pred);
    pdiff = 25'(pa) - 25'(pb);
    sum   = 26'(base) + 26'(pdiff >>> 6);
    if (sum > SAT_MAX) begin
      sat = 16'sh7fff;
    end else if (sum < SAT_MIN) begin
      sat = -16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  assign step     = !job_empty && job.decode && !res_full;
  assign res_push = step;
  assign job_pop  = !job_empty && (!job.decode || (step && phase_r));

  assign res.sample         = sat;
  assign res.sample_channel = ch_out;
  assign res.last_of_pair   = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        prev_r[i]  <= '0;
        prev2_r[i] <= '0;
      end
    end else begin
      if (step) begin
        phase_r <= !phase_r;
      end
      // end-of-call clear lands after the byte's last nibble
      if (job_pop && job.clear) begin
        prev_r[idx]  <= '0;
        prev2_r[idx] <= '0;
      end else if (step) begin
        prev_r[idx]  <= sat;
        prev2_r[idx] <= s1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vag_adpcm_decoder.sv =====
// ----------------------------------------------------------------------------
// vag_adpcm_decoder
// VAG ADPCM stream decoder: frame parser, job queue, sample datapath and
// result queue.
// ----------------------------------------------------------------------------
//  channel | ports                       | transfer when
//  input   | in_push, in_full, in_data   | in_push && !in_full
//  result  | out_pop, out_empty, out_data| out_pop && !out_empty
//
//  Header, flag and skipped bytes carry no nibbles; a data byte is decoded
//  in the sample datapath one nibble at a time, low nibble first, the
//  filter loop running through the history registers.
//  Reset is synchronous and clears history, frame state and both queues.
//  in_full follows the job queue; out_empty follows the result queue; the
//  datapath stalls on its own while the result queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module vag_adpcm_decoder
  import vagdec_pkg::*;
#(
  parameter int NUM_CHANNELS = 2,
  parameter int JOB_DEPTH    = 2,
  parameter int OUT_DEPTH    = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic      in_full,
  input  wire in_t  in_data,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data
);

  logic in_accept;
  logic job_valid;
  job_t job_in, job_out;
  logic job_full, job_empty, job_pop;
  logic res_full, res_push;
  out_t res;

  assign in_full   = job_full;
  assign in_accept = in_push && !job_full;

  vagdec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .item      (in_data),
    .job_valid (job_valid),
    .job       (job_in)
  );

  vagdec_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept && job_valid),
    .wr_data (job_in),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .full    (job_full),
    .empty   (job_empty)
  );

  vagdec_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  vagdec_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .rd_en   (out_pop),
    .rd_data (out_data),
    .full    (res_full),
    .empty   (out_empty)
  );

endmodule

`default_nettype wire

// ===== rtl/vagdec_checker.sv =====
// ----------------------------------------------------------------------------
// vagdec_port_checks
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vagdec_port_checks
  import vagdec_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_push,
  input wire logic in_full,
  input wire in_t  in_data,
  input wire logic out_empty,
  input wire logic out_pop,
  input wire out_t out_data
);

  // both queues come out of reset empty
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // an accepted input transfer carries known data
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |-> !$isunknown(in_data))
    else $error("unknown input data on transfer");

  // a waiting result holds until transferred
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("result changed before transfer");

  // the high-nibble sample follows its low-nibble partner promptly
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop && !out_data.last_of_pair |=> ##[0:1] !out_empty)
    else $error("second sample of pair missing");

endmodule

bind vag_adpcm_decoder vagdec_port_checks u_vagdec_port_checks (.*);

`default_nettype wire

// ===== tb/vagdec_checker.sv =====
// ----------------------------------------------------------------------------
// vagdec_checker
// Watches both queue channels of the VAG ADPCM decoder, decodes each accepted
// stream byte on its own copy of the frame and filter state, and compares
// every popped sample field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vagdec_checker
  import vagdec_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  input  logic in_full,
  input  in_t  in_data,
  input  logic out_empty,
  input  logic out_pop,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   checked
);

  localparam int CHANNELS    = 2;
  localparam int PRINT_LIMIT = 40;

  logic signed [15:0] s1_hist [CHANNELS];
  logic signed [15:0] s2_hist [CHANNELS];
  logic [3:0]         frame_pos;
  logic [3:0]         filter_sel;
  logic [3:0]         shift_amt;
  logic [7:0]         call_flags;
  logic               halted;
  out_t               sample_q [$];
  int                 errors = 0;
  int                 n_checked = 0;

  task automatic report(input string what);
    if (errors < PRINT_LIMIT) $display("%0t ns: sample check error: %s", $realtime, what);
    errors++;
  endtask

  // one filter step: scaled nibble plus the two-tap prediction, floor shifts, saturated to 16 bits
  function automatic logic signed [15:0] next_sample(input logic signed [15:0] s1,
                                                     input logic signed [15:0] s2,
                                                     input logic [3:0] nib,
                                                     input logic [3:0] sel,
                                                     input logic [3:0] sh);
    int base;
    int est;
    int v;
    int ka;
    int kb;
    case (sel)
      4'd1:    begin ka = 60;  kb = 0;  end
      4'd2:    begin ka = 115; kb = 52; end
      4'd3:    begin ka = 98;  kb = 55; end
      4'd4:    begin ka = 122; kb = 60; end
      default: begin ka = 0;   kb = 0;  end
    endcase
    base = nib[3] ? int'(nib) - 16 : int'(nib);
    base = (base * 4096) >>> sh;
    est  = (int'(s1) * ka - int'(s2) * kb) >>> 6;
    v    = base + est;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic take_byte(input in_t item);
    logic               ch;
    logic [3:0]         nib;
    logic signed [15:0] smp;
    out_t               r;
    int                 k;
    ch = item.channel;
    if (!halted) begin
      if (frame_pos == POS_HEADER) begin
        shift_amt  = item.stream_byte[3:0];
        filter_sel = item.stream_byte[7:4];
        if (shift_amt > MAX_SHIFT) halted = 1'b1;
      end else if (frame_pos == POS_FLAGS) begin
        call_flags = item.stream_byte;
        if (item.stream_byte == HALT_FLAG) halted = 1'b1;
      end else if (filter_sel < NUM_PRED) begin
        for (k = 0; k < 2; k++) begin
          nib = (k == 0) ? item.stream_byte[3:0] : item.stream_byte[7:4];
          smp = next_sample(s1_hist[ch], s2_hist[ch], nib, filter_sel, shift_amt);
          s2_hist[ch] = s1_hist[ch];
          s1_hist[ch] = smp;
          r.sample         = smp;
          r.sample_channel = ch;
          r.last_of_pair   = (k == 1);
          sample_q.push_back(r);
        end
      end
      if (!halted) frame_pos = (frame_pos == FRAME_LAST) ? POS_HEADER : frame_pos + 4'd1;
    end
    if (item.end_of_call) begin
      if (call_flags[0]) begin
        s1_hist[ch] = '0;
        s2_hist[ch] = '0;
      end
      frame_pos  = POS_HEADER;
      call_flags = '0;
      halted     = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    int   c;
    if (!rst_n) begin
      for (c = 0; c < CHANNELS; c++) begin
        s1_hist[c] = '0;
        s2_hist[c] = '0;
      end
      frame_pos  = POS_HEADER;
      filter_sel = '0;
      shift_amt  = '0;
      call_flags = '0;
      halted     = 1'b0;
      sample_q.delete();
    end else begin
      if (in_push && !in_full) take_byte(in_data);
      if (out_pop && !out_empty) begin
        if (sample_q.size() == 0) begin
          report($sformatf("unexpected sample %0d on channel %0d",
                           out_data.sample, out_data.sample_channel));
        end else begin
          want = sample_q.pop_front();
          n_checked++;
          if (out_data.sample !== want.sample)
            report($sformatf("sample %0d, predicted %0d", out_data.sample, want.sample));
          if (out_data.sample_channel !== want.sample_channel)
            report($sformatf("channel %0d, predicted %0d",
                             out_data.sample_channel, want.sample_channel));
          if (out_data.last_of_pair !== want.last_of_pair)
            report($sformatf("high-nibble mark %0d, predicted %0d",
                             out_data.last_of_pair, want.last_of_pair));
        end
      end
    end
    fail_count <= errors;
    pending    <= sample_q.size();
    checked    <= n_checked;
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the VAG ADPCM decoder: directed frames for the filter extremes,
// saturation, skipped frames, halts and history clears, then random calls of
// well-formed frames mixed with broken ones, under random gaps on both sides
// and two long result hold-offs. Checking is done in vagdec_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import vagdec_pkg::*;
();

  localparam int ITEM_TARGET  = 1350;
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 32;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_t  in_data;
  logic out_empty;
  logic out_pop;
  out_t out_data;

  int   fail_count;
  int   pending;
  int   checked;
  int   sent;
  int   quiet;
  bit   tx_steady;

  vag_adpcm_decoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  vagdec_checker sample_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0:       b = 8'h77;
      1:       b = 8'h88;
      2:       b = 8'h80;
      3:       b = 8'h08;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic ch, input logic eoc);
    in_t item;
    int  gap;
    item.stream_byte = b;
    item.channel     = ch;
    item.end_of_call = eoc;
    in_data <= item;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sent++;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // frame from the header up to last_pos; the call ends on its last byte if close
  task automatic send_frame(input logic [3:0] sel, input logic [3:0] shamt,
                            input logic [7:0] flags, input logic ch, input bit mix,
                            input int last_pos, input bit close);
    int         p;
    logic [7:0] b;
    logic       c;
    for (p = 0; p <= last_pos; p++) begin
      if (p == POS_HEADER) b = {sel, shamt};
      else if (p == POS_FLAGS) b = flags;
      else b = data_byte();
      c = mix ? 1'($urandom_range(0, 1)) : ch;
      push_byte(b, c, close && (p == last_pos));
    end
  endtask

  initial begin : stimulus
    int         kind;
    int         nframes;
    int         f;
    int         n;
    logic       ch;
    logic [7:0] flags;
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    out_pop   = 1'b0;
    sent      = 0;
    tx_steady = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // strongest filter at zero shift: positive then negative saturation, call ends mid-frame
    push_byte(8'h40, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h77, 1'b0, 1'b0);
    push_byte(8'h77, 1'b0, 1'b0);
    push_byte(8'h88, 1'b0, 1'b0);
    push_byte(8'h88, 1'b0, 1'b1);
    // largest legal shift on the right channel, flag bit 0 clears its history
    push_byte(8'h3C, 1'b1, 1'b0);
    push_byte(8'h01, 1'b1, 1'b0);
    push_byte(8'hF0, 1'b1, 1'b0);
    push_byte(8'h0F, 1'b1, 1'b1);
    // filters 1 and 2 on kept left history
    push_byte(8'h10, 1'b0, 1'b0);
    push_byte(8'h02, 1'b0, 1'b0);
    push_byte(8'h7F, 1'b0, 1'b1);
    push_byte(8'h26, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h9E, 1'b0, 1'b1);
    // unknown filter: data skipped
    push_byte(8'hF2, 1'b1, 1'b0);
    push_byte(8'h02, 1'b1, 1'b0);
    push_byte(8'hAB, 1'b1, 1'b1);
    // shift out of range halts until the call ends
    push_byte(8'h1D, 1'b0, 1'b0);
    push_byte(8'h12, 1'b0, 1'b0);
    push_byte(8'h34, 1'b0, 1'b1);
    // halt flag, which also has bit 0 set
    push_byte(8'h21, 1'b1, 1'b0);
    push_byte(HALT_FLAG, 1'b1, 1'b0);
    push_byte(8'h55, 1'b1, 1'b1);

    while (sent < ITEM_TARGET) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      ch        = 1'($urandom_range(0, 1));
      kind      = $urandom_range(0, 99);
      flags     = 8'($urandom);
      if (flags == HALT_FLAG) flags = 8'h00;
      if (kind < 72) begin
        nframes = $urandom_range(1, 3);
        for (f = 0; f < nframes; f++) begin
          flags = 8'($urandom);
          if (flags == HALT_FLAG) flags = 8'h00;
          send_frame(4'($urandom_range(0, 4)), 4'($urandom_range(0, 12)), flags, ch,
                     kind < 8, FRAME_LAST, f == nframes - 1);
        end
      end else if (kind < 80) begin
        send_frame(4'($urandom_range(5, 15)), 4'($urandom_range(0, 12)), flags, ch, 1'b0,
                   FRAME_LAST, 1'($urandom_range(0, 1)));
      end else if (kind < 86) begin
        send_frame(4'($urandom_range(0, 15)), 4'($urandom_range(13, 15)), flags, ch, 1'b0,
                   $urandom_range(1, 6), 1'b1);
      end else if (kind < 92) begin
        send_frame(4'($urandom_range(0, 4)), 4'($urandom_range(0, 12)), HALT_FLAG, ch, 1'b0,
                   $urandom_range(1, 8), 1'b1);
      end else if (kind < 96) begin
        send_frame(4'($urandom_range(0, 4)), 4'($urandom_range(0, 12)), flags, ch, 1'b0,
                   $urandom_range(0, 14), 1'b1);
      end else begin
        n = $urandom_range(4, 24);
        for (f = 0; f < n; f++)
          push_byte(8'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
        push_byte(8'($urandom), ch, 1'b1);
      end
    end

    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d stream bytes and %0d compared samples", sent, checked);
    $display("incl. all filters, saturation, skipped frames, halts and history clears");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int gap;
    int got;
    bit steady;
    got    = 0;
    steady = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pick_gap(steady);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      got++;
      if (got % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      // long hold-off so the decoder fills and backs up its input
      if (got == 150 || got == 1200) begin
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
